>>> rtl/pfx_pkg.sv
package pfx_pkg;

  // CORDIC datapath widths
  localparam int XYW = 33;  // x/y lanes, signed
  localparam int RZW = 34;  // rotation-mode residual angle, signed

  localparam int ANG_TAB_LEN = 24;

  // atan(2^-i) as 32-bit binary angles (2^32 = full turn), truncated
  localparam logic [31:0] ANG_TAB [ANG_TAB_LEN] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // gain-compensated 1.0 in Q30 and the Q30/Q14 unit values
  localparam logic signed [XYW-1:0] GAIN_Q30 = 33'sh26DD3B6A;
  localparam logic signed [XYW-1:0] ONE_Q30  = 33'sd1073741824;
  localparam logic signed [16:0]    Q14_ONE  = 17'sd16384;

  // saturation limits of a 32-bit result, held in 35 bits
  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  // register indexes on the APB port
  localparam logic [1:0] REG_OFFSET_X        = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y        = 2'd1;
  localparam logic [1:0] REG_OFFSET_HALF_YAW = 2'd2;
  localparam logic [1:0] REG_Z_BIAS          = 2'd3;

  // rotation-mode cell payload
  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic signed [RZW-1:0] z;
    logic                  neg;
  } rot_t;

  // vectoring-mode cell payload
  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic [31:0]           z;
    logic                  zero;
  } vec_t;

  // configuration registers
  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic [15:0]        offset_half_yaw;
    logic signed [31:0] z_bias;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] map_x;
    logic signed [31:0] map_y;
    logic signed [31:0] map_z;
    logic signed [15:0] out_quat_z;
    logic signed [15:0] out_quat_w;
  } pose_out_t;

endpackage

>>> rtl/pfx_in_if.sv
interface pfx_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, pos_x, pos_y, pos_z, quat_z, quat_w, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, quat_z, quat_w, output ready);
endinterface

>>> rtl/pfx_out_if.sv
interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] map_x;
  logic signed [31:0] map_y;
  logic signed [31:0] map_z;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_w;

  modport source (output valid, map_x, map_y, map_z, out_quat_z, out_quat_w, input ready);
  modport sink   (input valid, map_x, map_y, map_z, out_quat_z, out_quat_w, output ready);
endinterface

>>> rtl/planar_pose_frame_transform.sv
// Throughput: one pose per cycle while the output buffer is not full;
// set by the two CORDIC cell chains, one micro-rotation per cell, with
// position math running beside the second chain.
// A two-entry output buffer holds results; input stalls only when it is full.
// Reset (rst, synchronous): clears pipeline valid flags and the output buffer,
// and restores the configuration registers to their defaults.
module planar_pose_frame_transform
  import pfx_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  pfx_in_if.sink      odom,
  pfx_out_if.source   map
);

  localparam int N  = CORDIC_STAGES;
  localparam int NV = 2 * N + 2;

  cfg_t cfg;
  logic en;
  logic full;
  logic [NV-1:0] vld;

  // ---------------------------------------------------------------
  // helpers
  function automatic rot_t rot_init(input logic [15:0] ang);
    rot_t        r;
    logic        neg;
    logic [31:0] a;
    neg   = (ang > 16'h4000) && (ang < 16'hC000);
    a     = {ang ^ (neg ? 16'h8000 : 16'h0000), 16'h0000};
    r.x   = GAIN_Q30;
    r.y   = '0;
    r.z   = $signed({{2{a[31]}}, a});
    r.neg = neg;
    return r;
  endfunction

  function automatic vec_t vec_init(input logic signed [15:0] qz,
                                    input logic signed [15:0] qw);
    vec_t                  r;
    logic signed [XYW-1:0] xs;
    logic signed [XYW-1:0] ys;
    xs     = $signed({{3{qw[15]}}, qw, 14'b0});
    ys     = $signed({{3{qz[15]}}, qz, 14'b0});
    r.zero = (qw == 16'sd0) && (qz == 16'sd0);
    if (qw[15]) begin
      r.x = -xs;
      r.y = -ys;
      r.z = 32'h80000000;
    end else begin
      r.x = xs;
      r.y = ys;
      r.z = 32'h00000000;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] unit_clamp(input logic signed [XYW-1:0] v,
                                                    input logic neg);
    logic signed [XYW-1:0] nv;
    nv = neg ? -v : v;
    if (nv > ONE_Q30) begin
      return ONE_Q30[31:0];
    end else if (nv < -ONE_Q30) begin
      return -ONE_Q30[31:0];
    end
    return nv[31:0];
  endfunction

  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic signed [32:0] t;
    logic signed [16:0] h;
    t = $signed({v[31], v}) + 33'sd32768;
    h = t[32:16];
    if (h > Q14_ONE) begin
      h = Q14_ONE;
    end else if (h < -Q14_ONE) begin
      h = -Q14_ONE;
    end
    return h[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------
  // configuration port
  pfx_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------
  // flow control: the whole pipe advances unless the output buffer is full
  assign en         = !full;
  assign odom.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], odom.valid};
    end
  end

  // ---------------------------------------------------------------
  // input stage: seed both CORDIC chains, add z bias
  rot_t rot1_s0;
  vec_t vec1_s0;
  logic signed [31:0] px_d [0:N];
  logic signed [31:0] py_d [0:N];
  logic signed [31:0] mz_d [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rot1_s0 <= rot_init({cfg.offset_half_yaw[14:0], 1'b0});
      vec1_s0 <= vec_init(odom.quat_z, odom.quat_w);
      px_d[0] <= odom.pos_x;
      py_d[0] <= odom.pos_y;
      mz_d[0] <= sat32($signed({{3{odom.pos_z[31]}}, odom.pos_z})
                     + $signed({{3{cfg.z_bias[31]}}, cfg.z_bias}));
      for (int k = 1; k <= N; k++) begin
        px_d[k] <= px_d[k-1];
        py_d[k] <= py_d[k-1];
        mz_d[k] <= mz_d[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // first chain: yaw-offset sin/cos beside input half-yaw atan2
  rot_t rot1_lnk [0:N];
  vec_t vec1_lnk [0:N];

  assign rot1_lnk[0] = rot1_s0;
  assign vec1_lnk[0] = vec1_s0;

  for (genvar k = 0; k < N; k++) begin : g_chain1
    pfx_rot_cell #(.STAGE(k)) u_rot (
      .clk (clk), .en (en), .d (rot1_lnk[k]), .q (rot1_lnk[k+1])
    );
    pfx_vec_cell #(.STAGE(k)) u_vec (
      .clk (clk), .en (en), .d (vec1_lnk[k]), .q (vec1_lnk[k+1])
    );
  end

  // ---------------------------------------------------------------
  // middle stage: clamp offset sin/cos, round half-yaw, seed second chain
  logic signed [31:0] c1;
  logic signed [31:0] s1;
  logic signed [31:0] px_p1;
  logic signed [31:0] py_p1;
  logic signed [31:0] mz_p1;
  rot_t rot2_s0;
  logic [31:0] half_sum;
  logic [15:0] half;

  assign half_sum = vec1_lnk[N].z + 32'h00008000;
  assign half     = vec1_lnk[N].zero ? 16'h0000 : half_sum[31:16];

  always_ff @(posedge clk) begin
    if (en) begin
      c1      <= unit_clamp(rot1_lnk[N].x, rot1_lnk[N].neg);
      s1      <= unit_clamp(rot1_lnk[N].y, rot1_lnk[N].neg);
      px_p1   <= px_d[N];
      py_p1   <= py_d[N];
      mz_p1   <= mz_d[N];
      rot2_s0 <= rot_init(cfg.offset_half_yaw + half);
    end
  end

  // ---------------------------------------------------------------
  // second chain: sin/cos of the final half-yaw
  rot_t rot2_lnk [0:N];

  assign rot2_lnk[0] = rot2_s0;

  for (genvar k = 0; k < N; k++) begin : g_chain2
    pfx_rot_cell #(.STAGE(k)) u_rot (
      .clk (clk), .en (en), .d (rot2_lnk[k]), .q (rot2_lnk[k+1])
    );
  end

  // ---------------------------------------------------------------
  // position lane beside the second chain: multiply, sum, offset, delay
  logic signed [63:0] pxc;
  logic signed [63:0] pys;
  logic signed [63:0] pxs;
  logic signed [63:0] pyc;
  logic signed [31:0] mz_m1;
  logic signed [63:0] sx;
  logic signed [63:0] sy;
  logic signed [31:0] mz_m2;
  logic signed [34:0] mx_sum;
  logic signed [34:0] my_sum;
  logic signed [31:0] mx_d  [2:N-1];
  logic signed [31:0] my_d  [2:N-1];
  logic signed [31:0] mzo_d [2:N-1];

  assign mx_sum = $signed({sx[63], sx[63:30]})
                + $signed({{3{cfg.offset_x[31]}}, cfg.offset_x});
  assign my_sum = $signed({sy[63], sy[63:30]})
                + $signed({{3{cfg.offset_y[31]}}, cfg.offset_y});

  always_ff @(posedge clk) begin
    if (en) begin
      pxc      <= px_p1 * c1;
      pys      <= py_p1 * s1;
      pxs      <= px_p1 * s1;
      pyc      <= py_p1 * c1;
      mz_m1    <= mz_p1;
      sx       <= pxc - pys + 64'sd536870912;
      sy       <= pxs + pyc + 64'sd536870912;
      mz_m2    <= mz_m1;
      mx_d[2]  <= sat32(mx_sum);
      my_d[2]  <= sat32(my_sum);
      mzo_d[2] <= mz_m2;
      for (int k = 3; k < N; k++) begin
        mx_d[k]  <= mx_d[k-1];
        my_d[k]  <= my_d[k-1];
        mzo_d[k] <= mzo_d[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // final stage: clamp and round the quaternion, hand the result to the buffer
  pose_out_t res;
  logic signed [31:0] c2;
  logic signed [31:0] s2;

  assign c2 = unit_clamp(rot2_lnk[N].x, rot2_lnk[N].neg);
  assign s2 = unit_clamp(rot2_lnk[N].y, rot2_lnk[N].neg);

  always_comb begin
    res.map_x      = mx_d[N-1];
    res.map_y      = my_d[N-1];
    res.map_z      = mzo_d[N-1];
    res.out_quat_z = to_q14(s2);
    res.out_quat_w = to_q14(c2);
  end

  pfx_out_buf u_obuf (
    .clk  (clk),
    .rst  (rst),
    .push (en && vld[NV-1]),
    .d    (res),
    .full (full),
    .map  (map)
  );

endmodule

>>> rtl/pfx_rot_cell.sv
module pfx_rot_cell
  import pfx_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  rot_t d,
  output rot_t q
);

  logic signed [XYW-1:0] xs;
  logic signed [XYW-1:0] ys;
  logic signed [RZW-1:0] tab;

  assign xs  = $signed(d.x) >>> STAGE;
  assign ys  = $signed(d.y) >>> STAGE;
  assign tab = $signed({2'b00, ANG_TAB[STAGE]});

  // rotate toward zero residual angle, one micro-rotation per cell
  always_ff @(posedge clk) begin
    if (en) begin
      q.neg <= d.neg;
      if (!d.z[RZW-1]) begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - tab;
      end else begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + tab;
      end
    end
  end

endmodule

>>> rtl/pfx_vec_cell.sv
module pfx_vec_cell
  import pfx_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic clk,
  input  logic en,
  input  vec_t d,
  output vec_t q
);

  logic signed [XYW-1:0] xs;
  logic signed [XYW-1:0] ys;

  assign xs = $signed(d.x) >>> STAGE;
  assign ys = $signed(d.y) >>> STAGE;

  // drive y toward zero and accumulate the angle, wrapping mod a full turn
  always_ff @(posedge clk) begin
    if (en) begin
      q.zero <= d.zero;
      if (!d.y[XYW-1]) begin
        q.x <= d.x + ys;
        q.y <= d.y - xs;
        q.z <= d.z + ANG_TAB[STAGE];
      end else begin
        q.x <= d.x - ys;
        q.y <= d.y + xs;
        q.z <= d.z - ANG_TAB[STAGE];
      end
    end
  end

endmodule

>>> rtl/pfx_apb_regs.sv
module pfx_apb_regs
  import pfx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // write on the access phase of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_x        <= 32'sd16384;
      cfg.offset_y        <= 32'sd125043;
      cfg.offset_half_yaw <= 16'd0;
      cfg.z_bias          <= 32'sd1573;
    end else if (wr) begin
      case (paddr[3:2])
        REG_OFFSET_X:        cfg.offset_x        <= pwdata;
        REG_OFFSET_Y:        cfg.offset_y        <= pwdata;
        REG_OFFSET_HALF_YAW: cfg.offset_half_yaw <= pwdata[15:0];
        REG_Z_BIAS:          cfg.z_bias          <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_X:        prdata = cfg.offset_x;
      REG_OFFSET_Y:        prdata = cfg.offset_y;
      REG_OFFSET_HALF_YAW: prdata = {16'd0, cfg.offset_half_yaw};
      REG_Z_BIAS:          prdata = cfg.z_bias;
      default:             prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/pfx_out_buf.sv
module pfx_out_buf
  import pfx_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pose_out_t        d,
  output logic             full,
  pfx_out_if.source        map
);

  logic [1:0] count;
  pose_out_t  e0;
  pose_out_t  e1;
  logic       pop;

  assign pop  = map.valid && map.ready;
  assign full = (count == 2'd2);

  // track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // hold head in e0, spill a second result into e1
  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      e0 <= e1;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      e0 <= d;
    end
    if (push && count == 2'd1 && !pop) begin
      e1 <= d;
    end
  end

  assign map.valid      = (count != 2'd0);
  assign map.map_x      = e0.map_x;
  assign map.map_y      = e0.map_y;
  assign map.map_z      = e0.map_z;
  assign map.out_quat_z = e0.out_quat_z;
  assign map.out_quat_w = e0.out_quat_w;

endmodule
